[src/rgb_to_ansi_halfblock_encoder_core_macros.svh]
// Assertion macros shared by the encoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RGB_TO_ANSI_HALFBLOCK_ENCODER_CORE_MACROS_SVH
`define RGB_TO_ANSI_HALFBLOCK_ENCODER_CORE_MACROS_SVH

// Concurrent assertion on clk, disabled while rst_n is low.
`define AHBE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that something never happens.
`define AHBE_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[src/ahbe_pkg.sv]
// Shared types, constants and helpers for the half-block ANSI encoder.
// No dependencies; imported by every encoder module.
`timescale 1ns / 1ps

package ahbe_pkg;

    // Frame limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int PIX_W      = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd80;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd48;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Fixed text pieces; header and footer carry a trailing NUL byte
    localparam int HDR_LEN = 12;
    localparam int FG_LEN  = 7;
    localparam int BG_LEN  = 6;
    localparam int BLK_LEN = 4;
    localparam int FTR_LEN = 13;
    localparam int CNT_W   = 4;

    localparam logic [7:0] HDR_TXT [HDR_LEN] = '{
        8'h1b, 8'h5b, 8'h3f, 8'h32, 8'h30, 8'h32, 8'h36, 8'h68,
        8'h1b, 8'h5b, 8'h48, 8'h00};
    localparam logic [7:0] FG_TXT [FG_LEN] = '{
        8'h1b, 8'h5b, 8'h33, 8'h38, 8'h3b, 8'h32, 8'h3b};
    localparam logic [7:0] BG_TXT [BG_LEN] = '{
        8'h3b, 8'h34, 8'h38, 8'h3b, 8'h32, 8'h3b};
    localparam logic [7:0] BLK_TXT [BLK_LEN] = '{
        8'h6d, 8'he2, 8'h96, 8'h80};
    localparam logic [7:0] FTR_TXT [FTR_LEN] = '{
        8'h1b, 8'h5b, 8'h30, 8'h6d, 8'h1b, 8'h5b, 8'h3f, 8'h32,
        8'h30, 8'h32, 8'h36, 8'h6c, 8'h00};
    localparam logic [7:0] SEMI_CHAR  = 8'h3b;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;

    // One unit of work for the byte serializer
    typedef struct packed {
        logic             hdr;
        logic             pair;
        logic             ftr;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] lo;
    } cmd_t;

    // Serializer states
    typedef enum logic [2:0] {
        SER_IDLE,
        SER_HDR,
        SER_FG,
        SER_NUM,
        SER_SEP,
        SER_BG,
        SER_BLK,
        SER_FTR
    } ser_state_t;

    // Decimal digits of one 8-bit component
    typedef struct packed {
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [1:0] ndig;
    } dec_t;

    // Split 0..255 into digits; tens by reciprocal multiply (exact below 1029)
    function automatic dec_t to_dec(input logic [7:0] v);
        dec_t       d;
        logic [6:0] r;
        logic [14:0] prod;
        logic [6:0] t10;
        d.hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r      = 7'(v - 8'(d.hund) * 8'd100);
        prod   = 15'(r) * 15'd205;
        d.tens = prod[14:11];
        t10    = 7'(d.tens) * 7'd10;
        d.ones = 4'(r - t10);
        d.ndig = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
        return d;
    endfunction

endpackage

[src/rgb_to_ansi_halfblock_encoder_core.sv]
// Top level of the half-block ANSI encoder: front classifier, command queue
// and byte serializer. Depends on ahbe_pkg, ahbe_front, ahbe_fifo, ahbe_back.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+--------------------------------
//  pixel in | push / full           | red, green, blue
//  bytes out| empty / pop           | out_byte, last_of_run
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A pixel is taken whenever the queue has room, counting the one in the classify
// stage. The serializer emits one byte per cycle while the output is not stalled
// and loads each command in an idle step; a pixel that draws a cell emits 27 to
// 39 bytes (header adds 12, footer 13), an upper-row pixel none (12 with header).
// Reset restores 80 x 48 and position zero; the line store is not cleared.
// A stalled output holds its byte and the queue back-pressures the input.
`timescale 1ns / 1ps

module rgb_to_ansi_halfblock_encoder_core
    import ahbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               cmd_push;
    cmd_t               cmd_in;
    cmd_t               cmd_out;
    logic               cmd_valid;
    logic               cmd_pop;
    logic [FIFO_CW-1:0] cmd_count;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    ahbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .push       (push),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .fifo_count (cmd_count),
        .full       (full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    ahbe_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .rd_en    (cmd_pop),
        .rd_data  (cmd_out),
        .rd_valid (cmd_valid),
        .count    (cmd_count)
    );

    ahbe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_valid  (cmd_valid),
        .fifo_cmd    (cmd_out),
        .fifo_pop    (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

[src/ahbe_fifo.sv]
// Small command queue between the classifier front and the byte serializer.
// Depends on ahbe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rgb_to_ansi_halfblock_encoder_core_macros.svh"

module ahbe_fifo
    import ahbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  cmd_t               wr_data,
    input  logic               rd_en,
    output cmd_t               rd_data,
    output logic               rd_valid,
    output logic [FIFO_CW-1:0] count
);

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = FIFO_AW'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = FIFO_AW'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = FIFO_CW'(count_reg + 1'b1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = FIFO_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data  = slot_reg[rd_ptr_reg];
    assign rd_valid = (count_reg != '0);
    assign count    = count_reg;

    `AHBE_NEVER(a_no_overflow, wr_en && !rd_en && (count_reg == FIFO_CW'(FIFO_DEPTH)), "command queue overflow")
    `AHBE_NEVER(a_no_underflow, rd_en && (count_reg == '0), "command queue underflow")
    `AHBE_ASSERT(a_level_tracks_ptrs, (count_reg == FIFO_CW'(FIFO_DEPTH)) || (FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0]), "queue level disagrees with pointers")

endmodule

[src/ahbe_front.sv]
// Front end: configuration registers, raster position, upper-row line store,
// and classification of each pixel into a serializer command. Uses ahbe_pkg.
`timescale 1ns / 1ps

module ahbe_front
    import ahbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  push,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [FIFO_CW-1:0]    fifo_count,
    output logic                  full,
    output logic                  cmd_push,
    output cmd_t                  cmd
);

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s1_valid_reg;
    logic             s1_hdr_reg, s1_cell_reg, s1_ftr_reg, s1_odd_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] rd_data_reg;
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];

    logic               accept;
    logic [FW_W-1:0]    w_eff;
    logic [FH_W-1:0]    h_eff;
    logic               last_col, last_row, odd_row, is_hdr, do_store;
    logic [PIX_W-1:0]   pix;
    logic [FIFO_CW-1:0] level;

    // Room check counts the item still in the classify stage
    assign level  = FIFO_CW'(fifo_count + FIFO_CW'(s1_valid_reg));
    assign full   = (level >= FIFO_CW'(FIFO_DEPTH));
    assign accept = push && !full;
    assign pix    = {red, green, blue};

    // Clamp sizes and classify the incoming pixel
    always_comb
    begin
        w_eff = frame_width_reg;
        if (frame_width_reg == '0)
        begin
            w_eff = FW_W'(1);
        end
        else if (frame_width_reg > FW_W'(MAX_WIDTH))
        begin
            w_eff = FW_W'(MAX_WIDTH);
        end
        h_eff = frame_height_reg;
        if (frame_height_reg == '0)
        begin
            h_eff = FH_W'(1);
        end
        else if (frame_height_reg > FH_W'(MAX_HEIGHT))
        begin
            h_eff = FH_W'(MAX_HEIGHT);
        end
        last_col = (FW_W'(col_reg) + FW_W'(1)) >= w_eff;
        last_row = (FH_W'(row_reg) + FH_W'(1)) >= h_eff;
        odd_row  = row_reg[0];
        is_hdr   = (col_reg == '0) && (row_reg == '0);
        do_store = !odd_row && !last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : ROW_W'(row_reg + 1'b1);
        end
        else
        begin
            col_next = COL_W'(col_reg + 1'b1);
        end
    end

    // Configuration and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                    default:          frame_width_reg  <= frame_width_reg;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
        end
    end

    // Classify stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hdr_reg  <= is_hdr;
            s1_cell_reg <= odd_row || last_row;
            s1_ftr_reg  <= last_col && last_row;
            s1_odd_reg  <= odd_row;
            s1_pix_reg  <= pix;
        end
    end

    // Upper-row line store: at most one write or one read per accepted pixel
    always_ff @(posedge clk)
    begin
        if (accept && do_store)
        begin
            line_mem[col_reg] <= pix;
        end
        if (accept && odd_row)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
    end

    // Build the command; an even last row pairs with black
    always_comb
    begin
        cmd.hdr  = s1_hdr_reg;
        cmd.pair = s1_cell_reg;
        cmd.ftr  = s1_ftr_reg;
        cmd.up   = s1_odd_reg ? rd_data_reg : s1_pix_reg;
        cmd.lo   = s1_odd_reg ? s1_pix_reg : '0;
        cmd_push = s1_valid_reg && (s1_hdr_reg || s1_cell_reg || s1_ftr_reg);
    end

endmodule

[src/ahbe_back.sv]
// Back end: walks one command at a time and emits its bytes into an
// output register, one byte per cycle while the output is not stalled. Uses ahbe_pkg.
`timescale 1ns / 1ps

module ahbe_back
    import ahbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fifo_valid,
    input  cmd_t       fifo_cmd,
    output logic       fifo_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    ser_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       comp_reg, comp_next;
    cmd_t             cmd_reg, cmd_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;

    logic       adv, emit, emit_last;
    logic [7:0] emit_byte;
    logic [7:0] comp_val;
    dec_t       dec;
    logic [1:0] dig_pos;
    logic [3:0] dig_val;
    logic       dig_last;

    assign adv = !out_valid_reg || pop;

    // Current color component and its digit
    always_comb
    begin
        unique case (comp_reg)
            3'd0:    comp_val = cmd_reg.up[23:16];
            3'd1:    comp_val = cmd_reg.up[15:8];
            3'd2:    comp_val = cmd_reg.up[7:0];
            3'd3:    comp_val = cmd_reg.lo[23:16];
            3'd4:    comp_val = cmd_reg.lo[15:8];
            3'd5:    comp_val = cmd_reg.lo[7:0];
            default: comp_val = '0;
        endcase
        dec     = to_dec(comp_val);
        dig_pos = 2'(cnt_reg[1:0] + (2'd3 - dec.ndig));
        unique case (dig_pos)
            2'd0:    dig_val = 4'(dec.hund);
            2'd1:    dig_val = dec.tens;
            default: dig_val = dec.ones;
        endcase
        dig_last = (cnt_reg[1:0] == 2'(dec.ndig - 2'd1));
    end

    // Sequencer: next state and emitted byte
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cmd_next   = cmd_reg;
        fifo_pop   = 1'b0;
        emit       = 1'b0;
        emit_byte  = '0;
        emit_last  = 1'b0;

        if (state_reg == SER_IDLE)
        begin
            if (fifo_valid)
            begin
                fifo_pop = 1'b1;
                cmd_next = fifo_cmd;
                cnt_next = '0;
                priority if (fifo_cmd.hdr)
                begin
                    state_next = SER_HDR;
                end
                else if (fifo_cmd.pair)
                begin
                    state_next = SER_FG;
                end
                else
                begin
                    state_next = SER_FTR;
                end
            end
        end
        else if (adv)
        begin
            emit     = 1'b1;
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            unique case (state_reg)
                SER_HDR:
                begin
                    emit_byte = HDR_TXT[cnt_reg];
                    if (cnt_reg == CNT_W'(HDR_LEN - 1))
                    begin
                        cnt_next = '0;
                        priority if (cmd_reg.pair)
                        begin
                            state_next = SER_FG;
                        end
                        else if (cmd_reg.ftr)
                        begin
                            state_next = SER_FTR;
                        end
                        else
                        begin
                            state_next = SER_IDLE;
                            emit_last  = 1'b1;
                        end
                    end
                end
                SER_FG:
                begin
                    emit_byte = FG_TXT[cnt_reg[2:0]];
                    if (cnt_reg == CNT_W'(FG_LEN - 1))
                    begin
                        cnt_next   = '0;
                        comp_next  = 3'd0;
                        state_next = SER_NUM;
                    end
                end
                SER_NUM:
                begin
                    emit_byte = ZERO_CHAR + 8'(dig_val);
                    if (dig_last)
                    begin
                        cnt_next = '0;
                        priority if (comp_reg == 3'd2)
                        begin
                            state_next = SER_BG;
                        end
                        else if (comp_reg == 3'd5)
                        begin
                            state_next = SER_BLK;
                        end
                        else
                        begin
                            state_next = SER_SEP;
                        end
                    end
                end
                SER_SEP:
                begin
                    emit_byte  = SEMI_CHAR;
                    cnt_next   = '0;
                    comp_next  = 3'(comp_reg + 1'b1);
                    state_next = SER_NUM;
                end
                SER_BG:
                begin
                    emit_byte = BG_TXT[cnt_reg[2:0]];
                    if (cnt_reg == CNT_W'(BG_LEN - 1))
                    begin
                        cnt_next   = '0;
                        comp_next  = 3'd3;
                        state_next = SER_NUM;
                    end
                end
                SER_BLK:
                begin
                    emit_byte = BLK_TXT[cnt_reg[1:0]];
                    if (cnt_reg == CNT_W'(BLK_LEN - 1))
                    begin
                        cnt_next = '0;
                        if (cmd_reg.ftr)
                        begin
                            state_next = SER_FTR;
                        end
                        else
                        begin
                            state_next = SER_IDLE;
                            emit_last  = 1'b1;
                        end
                    end
                end
                SER_FTR:
                begin
                    emit_byte = FTR_TXT[cnt_reg];
                    if (cnt_reg == CNT_W'(FTR_LEN - 1))
                    begin
                        cnt_next   = '0;
                        state_next = SER_IDLE;
                        emit_last  = 1'b1;
                    end
                end
                default:
                begin
                    state_next = SER_IDLE;
                end
            endcase
        end

        out_valid_next = (out_valid_reg && !pop) || emit;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SER_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit)
        begin
            byte_reg <= emit_byte;
            last_reg <= emit_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

endmodule

[sim/tb_top.sv]
// Self-checking bench for the half-block ANSI encoder core: pixels in, terminal text out.
// Depends on ahbe_pkg and rgb_to_ansi_halfblock_encoder_core; the byte stream is
// predicted inside the bench and checked byte by byte.
`timescale 1ns / 1ps

module tb_top
    import ahbe_pkg::*;
();

    // Text pieces of the output stream, right-aligned, first byte highest
    localparam logic [95:0]  SYNC_ON   = {8'h1b, "[?2026h", 8'h1b, "[H", 8'h00};
    localparam logic [103:0] SYNC_OFF  = {8'h1b, "[0m", 8'h1b, "[?2026l", 8'h00};
    localparam logic [55:0]  FG_OPEN   = {8'h1b, "[38;2;"};
    localparam logic [47:0]  BG_OPEN   = ";48;2;";
    localparam logic [31:0]  HALF_BLK  = {"m", 8'he2, 8'h96, 8'h80};
    localparam logic [7:0]   ASCII_0   = 8'h30;
    localparam logic [7:0]   SEMICOLON = 8'h3b;
    localparam int           STORE_LEN = 1024;
    localparam int           SETTLE    = 80;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [7:0] data;
        logic       tail;
    } text_byte_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            red = 8'd0;
    logic [7:0]            green = 8'd0;
    logic [7:0]            blue = 8'd0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            out_byte;
    logic                  last_of_run;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rgb_to_ansi_halfblock_encoder_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Predicted encoder state
    logic [FW_W-1:0]  width_reg = FRAME_WIDTH_RST;
    logic [FH_W-1:0]  height_reg = FRAME_HEIGHT_RST;
    logic [23:0]      upper_line [STORE_LEN];
    int               col_pos = 0;
    int               row_pos = 0;

    pixel_t           pixel_queue[$];
    text_byte_t       expected_text[$];
    logic [7:0]       pixel_text[$];
    int               send_gap_pct = 0;
    int               pop_gap_pct = 0;
    int               mismatches = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Text building for one pixel
    function automatic void put_byte(input logic [7:0] b);
        pixel_text.push_back(b);
    endfunction

    function automatic void put_text(input logic [103:0] txt, input int n);
        for (int i = n - 1; i >= 0; i--)
            put_byte(txt[i*8 +: 8]);
    endfunction

    // Decimal, 1 to 3 digits, no leading zeros
    function automatic void put_dec(input logic [7:0] v);
        if (v >= 8'd100)
        begin
            put_byte(ASCII_0 + v / 8'd100);
            put_byte(ASCII_0 + (v % 8'd100) / 8'd10);
            put_byte(ASCII_0 + v % 8'd10);
        end
        else if (v >= 8'd10)
        begin
            put_byte(ASCII_0 + v / 8'd10);
            put_byte(ASCII_0 + v % 8'd10);
        end
        else
            put_byte(ASCII_0 + v);
    endfunction

    function automatic void put_rgb(input logic [23:0] c);
        put_dec(c[23:16]);
        put_byte(SEMICOLON);
        put_dec(c[15:8]);
        put_byte(SEMICOLON);
        put_dec(c[7:0]);
    endfunction

    function automatic void put_cell(input logic [23:0] up, input logic [23:0] lo);
        put_text(104'(FG_OPEN), 7);
        put_rgb(up);
        put_text(104'(BG_OPEN), 6);
        put_rgb(lo);
        put_text(104'(HALF_BLK), 4);
    endfunction

    // Advance the predicted encoder by one pixel and queue its text
    function automatic void encode_pixel(input logic [23:0] pix);
        int         w;
        int         h;
        bit         last_col;
        bit         last_row;
        text_byte_t t;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        if (col_pos >= MAX_WIDTH)
            col_pos = MAX_WIDTH - 1;
        pixel_text.delete();
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);

        if (col_pos == 0 && row_pos == 0)
            put_text(104'(SYNC_ON), 12);

        // lower row pairs with the stored pixel; an even last row pairs with black
        if (row_pos % 2 == 1)
            put_cell(upper_line[col_pos], pix);
        else if (last_row)
            put_cell(pix, 24'h0);
        else
            upper_line[col_pos] = pix;

        if (last_col)
        begin
            col_pos = 0;
            if (last_row)
            begin
                row_pos = 0;
                put_text(SYNC_OFF, 13);
            end
            else
                row_pos++;
        end
        else
            col_pos++;

        foreach (pixel_text[i])
        begin
            t.data = pixel_text[i];
            t.tail = (i == pixel_text.size() - 1);
            expected_text.push_back(t);
        end
    endfunction

    // Pixel driver
    always @(posedge clk or negedge rst_n)
    begin : sender
        pixel_t taken;
        logic   go;
        if (!rst_n)
        begin
            push  <= 1'b0;
            red   <= 8'd0;
            green <= 8'd0;
            blue  <= 8'd0;
        end
        else
        begin
            if (push && !full)
            begin
                taken = pixel_queue.pop_front();
                encode_pixel({taken.r, taken.g, taken.b});
            end
            // hold an offered item until taken, else offer the next one at random
            go = push && full;
            if (!go && pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                go = 1'b1;
            if (go)
            begin
                red   <= pixel_queue[0].r;
                green <= pixel_queue[0].g;
                blue  <= pixel_queue[0].b;
            end
            push <= go;
        end
    end

    // Byte monitor and pop control
    always @(posedge clk or negedge rst_n)
    begin : receiver
        text_byte_t want;
        logic       take;
        int         bytes_seen;
        int         hold_left;
        bit         held_once;
        if (!rst_n)
        begin
            pop        <= 1'b0;
            bytes_seen = 0;
            hold_left  = 0;
            held_once  = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_text.size() == 0)
                    flag_error($sformatf("byte %0d: unexpected %02h last %0b",
                                         bytes_seen, out_byte, last_of_run));
                else
                begin
                    want = expected_text.pop_front();
                    if (out_byte !== want.data || last_of_run !== want.tail)
                        flag_error($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                             bytes_seen, want.data, want.tail,
                                             out_byte, last_of_run));
                end
                bytes_seen++;
            end
            // one long hold-off while many pixels are still to come, so the input backs up
            if (!held_once && bytes_seen >= 300 && push && pixel_queue.size() >= 10)
            begin
                held_once = 1;
                hold_left = 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
                take = ($urandom_range(0, 99) >= pop_gap_pct);
            pop <= take;
        end
    end

    function automatic void queue_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        pixel_t p;
        p.r = r;
        p.g = g;
        p.b = b;
        pixel_queue.push_back(p);
    endfunction

    // Spread components over one, two and three digit values
    function automatic logic [7:0] rand_comp();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            2:       return 8'($urandom_range(100, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            width_reg = val[FW_W-1:0];
        else
            height_reg = val[FH_W-1:0];
    endtask

    // Waits until every queued pixel is sent, every expected byte is out and the block has settled
    task automatic drain();
        while (pixel_queue.size() != 0 || push || expected_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Start an upper row at clamped full width; fills every column read later
        write_reg(CFG_FRAME_WIDTH, 13'h1fff);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        for (int i = 0; i < 8; i++)
            queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        drain();

        // Width zero in mid-frame: the current column becomes the last one
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        queue_pixel(8'd17, 8'd200, 8'd3);
        queue_pixel(8'd255, 8'd0, 8'd9);
        drain();

        // Odd height, 3 x 3, digit-count boundaries
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        queue_pixel(8'd0, 8'd9, 8'd10);
        queue_pixel(8'd99, 8'd100, 8'd255);
        queue_pixel(8'd200, 8'd199, 8'd1);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd10, 8'd99, 8'd100);
        queue_pixel(8'd255, 8'd0, 8'd128);
        queue_pixel(8'd9, 8'd10, 8'd99);
        queue_pixel(8'd100, 8'd255, 8'd0);
        drain();

        // Single-pixel frames: header, cell with black and footer each time
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0, 8'd0, 8'd0);
        drain();
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        queue_pixel(8'd100, 8'd10, 8'd1);
        drain();

        // Clamped tall frame, then height cut in mid-frame
        write_reg(CFG_FRAME_WIDTH, 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'h1fff);
        for (int i = 0; i < 5; i++)
            queue_pixel(rand_comp(), rand_comp(), rand_comp());
        drain();
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        queue_pixel(8'd1, 8'd22, 8'd233);
        queue_pixel(8'd77, 8'd5, 8'd150);
        drain();

        // Random phases: sender gaps, receiver gaps, then full rate
        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap_pct = (ph == 0) ? 20 : ((ph == 1) ? 75 : 0);
            pop_gap_pct  = (ph == 0) ? 75 : ((ph == 1) ? 20 : 0);
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_FRAME_WIDTH, 13'd0);
            else
                write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(1, 6)));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 1) ? 13'd0 : 13'h1fff);
            else
                write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(1, 5)));
            for (int i = 0; i < 27; i++)
                queue_pixel(rand_comp(), rand_comp(), rand_comp());
            drain();
        end

        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/ahbe_pkg.sv
src/ahbe_fifo.sv
src/ahbe_front.sv
src/ahbe_back.sv
src/rgb_to_ansi_halfblock_encoder_core.sv
sim/tb_top.sv
